// File: rtl/poly_pkg.sv
`default_nettype none

package poly_pkg;

    localparam int NLIMB   = 5;
    localparam int LIMB_W  = 26;
    localparam int ACC_W   = 27;
    localparam int H_W     = 28;
    localparam int R_W     = 29;
    localparam int PROD_W  = H_W + R_W;
    localparam int D_W     = 64;
    localparam int CARRY_W = D_W - LIMB_W;
    localparam int FIN_W   = 32;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 64;
    localparam int CNT_W   = 5;

    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [LIMB_W-1:0] CLAMP1    = 26'h3ffff03;
    localparam logic [LIMB_W-1:0] CLAMP2    = 26'h3ffc0ff;
    localparam logic [LIMB_W-1:0] CLAMP3    = 26'h3f03fff;
    localparam logic [LIMB_W-1:0] CLAMP4    = 26'h00fffff;
    localparam logic [CNT_W-1:0]  FULL_CNT  = 5'd16;
    localparam logic [IDX_W-1:0]  LAST_LIMB = 3'd4;
    localparam logic [IDX_W-1:0]  FOLD      = 3'd5;

    typedef enum logic [1:0] {
        CFG_R_LOW  = 2'd0,
        CFG_R_HIGH = 2'd1,
        CFG_S_LOW  = 2'd2,
        CFG_S_HIGH = 2'd3
    } cfg_idx_e;

    typedef logic [NLIMB-1:0][LIMB_W-1:0] limb_vec_t;
    typedef logic [NLIMB-1:0][ACC_W-1:0]  acc_vec_t;
    typedef logic [NLIMB-1:0][H_W-1:0]    h_vec_t;
    typedef logic [NLIMB-1:0][D_W-1:0]    d_vec_t;
    typedef logic [NLIMB-1:0][FIN_W-1:0]  fin_vec_t;

    typedef struct packed {
        logic [63:0]      block_low;
        logic [63:0]      block_high;
        logic [CNT_W-1:0] byte_count;
        logic             last;
    } poly_in_t;

    typedef struct packed {
        logic [63:0] tag_low;
        logic [63:0] tag_high;
    } poly_out_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] dst;
        logic [H_W-1:0]   a;
        logic [R_W-1:0]   b;
    } mul_req_t;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  dst;
        logic [PROD_W-1:0] prod;
    } mul_rsp_t;

    function automatic limb_vec_t clamp_r(input logic [63:0] r_lo, input logic [63:0] r_hi);
        limb_vec_t r;
        r[0] = r_lo[25:0];
        r[1] = r_lo[51:26] & CLAMP1;
        r[2] = {r_hi[13:0], r_lo[63:52]} & CLAMP2;
        r[3] = r_hi[39:14] & CLAMP3;
        r[4] = {2'b00, r_hi[63:40]} & CLAMP4;
        return r;
    endfunction

    // Split a block into limbs; a short block gets its marker byte, a full one the 2^128 bit.
    function automatic limb_vec_t msg_limbs(input logic [63:0] lo, input logic [63:0] hi,
                                            input logic [CNT_W-1:0] n);
        logic [127:0] m;
        logic [127:0] bitpos;
        logic         full;
        limb_vec_t    l;
        full   = (n >= FULL_CNT);
        m      = {hi, lo};
        bitpos = 128'd1 << {n[3:0], 3'b000};
        if (!full) begin
            m = (m & (bitpos - 128'd1)) | bitpos;
        end
        l[0] = m[25:0];
        l[1] = m[51:26];
        l[2] = m[77:52];
        l[3] = m[103:78];
        l[4] = {1'b0, full, m[127:104]};
        return l;
    endfunction

endpackage

`default_nettype wire

// File: rtl/poly_mul.sv
`default_nettype none

module poly_mul
    import poly_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);

    mul_rsp_t rsp_reg;
    mul_rsp_t rsp_next;

    always_comb begin
        rsp_next.valid = req.valid;
        rsp_next.dst   = req.dst;
        rsp_next.prod  = PROD_W'(req.a) * PROD_W'(req.b);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rsp_reg.valid <= 1'b0;
        end else begin
            rsp_reg.valid <= rsp_next.valid;
        end
        rsp_reg.dst  <= rsp_next.dst;
        rsp_reg.prod <= rsp_next.prod;
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/poly_fin.sv
`default_nettype none

module poly_fin
    import poly_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire acc_vec_t    acc,
    input  wire logic [63:0] s_low,
    input  wire logic [63:0] s_high,
    output logic             done,
    output poly_out_t        tag
);

    logic         v1_reg, v2_reg, v3_reg;
    fin_vec_t     h1_reg, h1_next;
    logic [127:0] p2_reg, p2_next;
    poly_out_t    tag_reg, tag_next;

    // Stage 1: propagate carries through all limbs, wrapping the top one with the fold.
    always_comb begin
        fin_vec_t           h;
        logic [FIN_W-1:0]   c;
        for (int i = 0; i < NLIMB; i++) begin
            h[i] = FIN_W'(acc[i]);
        end
        c = h[1] >> LIMB_W; h[1] = h[1] & FIN_W'(LIMB_MASK); h[2] = h[2] + c;
        c = h[2] >> LIMB_W; h[2] = h[2] & FIN_W'(LIMB_MASK); h[3] = h[3] + c;
        c = h[3] >> LIMB_W; h[3] = h[3] & FIN_W'(LIMB_MASK); h[4] = h[4] + c;
        c = h[4] >> LIMB_W; h[4] = h[4] & FIN_W'(LIMB_MASK);
        h[0] = h[0] + c * FIN_W'(FOLD);
        c = h[0] >> LIMB_W; h[0] = h[0] & FIN_W'(LIMB_MASK); h[1] = h[1] + c;
        h1_next = h;
    end

    // Stage 2: subtract the prime when it does not go negative, then pack to 128 bits.
    always_comb begin
        fin_vec_t         g;
        fin_vec_t         h;
        logic [FIN_W-1:0] c;
        logic [63:0]      lo, hi;
        h    = h1_reg;
        g[0] = h[0] + FIN_W'(FOLD);
        c    = g[0] >> LIMB_W;
        g[0] = g[0] & FIN_W'(LIMB_MASK);
        for (int i = 1; i < NLIMB - 1; i++) begin
            g[i] = h[i] + c;
            c    = g[i] >> LIMB_W;
            g[i] = g[i] & FIN_W'(LIMB_MASK);
        end
        g[4] = h[4] + c - (FIN_W'(1) << LIMB_W);
        if (!g[4][FIN_W-1]) begin
            h = g;
        end
        lo = 64'(h[0]) | (64'(h[1]) << 26) | (64'(h[2]) << 52);
        hi = (64'(h[2]) >> 12) | (64'(h[3]) << 14) | (64'(h[4]) << 40);
        p2_next = {hi, lo};
    end

    // Stage 3: add the pad modulo 2^128.
    always_comb begin
        logic [127:0] sum;
        sum = p2_reg + {s_high, s_low};
        tag_next.tag_low  = sum[63:0];
        tag_next.tag_high = sum[127:64];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        h1_reg  <= h1_next;
        p2_reg  <= p2_next;
        tag_reg <= tag_next;
    end

    assign done = v3_reg;
    assign tag  = tag_reg;

endmodule

`default_nettype wire

// File: rtl/poly1305_mac.sv
// Poly1305 authenticator over 16-byte message beats. Write r and s through the cfg port while
// the block is idle; r is clamped inside. Each beat with a nonzero byte_count is absorbed
// between acceptance and the return of s_ready: the single shared 28x29 multiplier forms
// the limb products of h*r mod 2^130-5, then follow a pipeline drain, a carry pass over all
// limbs and a fold. A beat with byte_count below 16 or with last set also produces the tag:
// the accumulator is handed over once the output register is free, then goes through final
// reduction and pad addition, and the accumulator starts over at zero. A beat with byte_count
// 0 only emits the tag. Counts above 16 count as 16.
`default_nettype none

module poly1305_mac
    import poly_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire poly_in_t         s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output poly_out_t             m_data,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_idx,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DRAIN = 7'b0000100,
        ST_CARRY = 7'b0001000,
        ST_FOLD  = 7'b0010000,
        ST_FWAIT = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     r_low_reg, r_high_reg, s_low_reg, s_high_reg;
    acc_vec_t             acc_reg, acc_next;
    h_vec_t               h_reg, h_next;
    d_vec_t               d_reg, d_next;
    logic [CARRY_W-1:0]   c_reg, c_next;
    logic [IDX_W-1:0]     i_reg, i_next, j_reg, j_next;
    logic                 fin_pend_reg, fin_pend_next;
    logic                 m_valid_reg, m_valid_next;
    poly_out_t            m_data_reg, m_data_next;

    limb_vec_t            r_vec;
    limb_vec_t            m_vec;
    logic [IDX_W-1:0]     k_idx;
    logic [R_W-1:0]       r_sel;
    mul_req_t             req;
    mul_rsp_t             rsp;
    logic                 fin_start;
    logic                 fin_done;
    poly_out_t            fin_tag;
    logic                 s_fire;

    assign r_vec  = clamp_r(r_low_reg, r_high_reg);
    assign m_vec  = msg_limbs(s_data.block_low, s_data.block_high, s_data.byte_count);
    assign s_fire = s_valid && s_ready;

    // Limb of r paired with h[j] for d[i]; wrapped terms use 5*r.
    always_comb begin
        k_idx = (j_reg <= i_reg) ? (i_reg - j_reg) : (i_reg + FOLD - j_reg);
        r_sel = R_W'(r_vec[k_idx]);
        if (j_reg > i_reg) begin
            r_sel = (r_sel << 2) + r_sel;
        end
        req.valid = (state_reg == ST_MUL);
        req.dst   = i_reg;
        req.a     = h_reg[j_reg];
        req.b     = r_sel;
    end

    poly_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .rsp     (rsp)
    );

    poly_fin u_fin (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (fin_start),
        .acc     (acc_reg),
        .s_low   (s_low_reg),
        .s_high  (s_high_reg),
        .done    (fin_done),
        .tag     (fin_tag)
    );

    always_comb begin
        logic [D_W-1:0]         t;
        logic [CARRY_W+4-1:0]   f;
        state_next    = state_reg;
        acc_next      = acc_reg;
        h_next        = h_reg;
        d_next        = d_reg;
        c_next        = c_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        fin_pend_next = fin_pend_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        fin_start     = 1'b0;
        t             = '0;
        f             = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (rsp.valid) begin
            d_next[rsp.dst] = d_reg[rsp.dst] + D_W'(rsp.prod);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    fin_pend_next = (s_data.byte_count < FULL_CNT) || s_data.last;
                    if (s_data.byte_count != '0) begin
                        for (int n = 0; n < NLIMB; n++) begin
                            h_next[n] = H_W'(acc_reg[n]) + H_W'(m_vec[n]);
                            d_next[n] = '0;
                        end
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ST_MUL;
                    end else begin
                        state_next = ST_FWAIT;
                    end
                end
            end
            ST_MUL: begin
                if (j_reg == LAST_LIMB) begin
                    j_next = '0;
                    if (i_reg == LAST_LIMB) begin
                        state_next = ST_DRAIN;
                    end else begin
                        i_next = i_reg + 1'b1;
                    end
                end else begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                // last product lands in d this cycle
                c_next     = '0;
                i_next     = '0;
                state_next = ST_CARRY;
            end
            ST_CARRY: begin
                t                = d_reg[i_reg] + D_W'(c_reg);
                c_next           = t[D_W-1:LIMB_W];
                acc_next[i_reg]  = ACC_W'(t[LIMB_W-1:0]);
                if (i_reg == LAST_LIMB) begin
                    state_next = ST_FOLD;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_FOLD: begin
                f           = (CARRY_W+4)'(acc_reg[0]) + ((CARRY_W+4)'(c_reg) << 2)
                              + (CARRY_W+4)'(c_reg);
                acc_next[0] = ACC_W'(f[LIMB_W-1:0]);
                acc_next[1] = acc_reg[1] + ACC_W'(f[CARRY_W+4-1:LIMB_W]);
                state_next  = fin_pend_reg ? ST_FWAIT : ST_IDLE;
            end
            ST_FWAIT: begin
                // start only with the output register free, so the tag has a place to land
                if (!m_valid_reg || m_ready) begin
                    fin_start  = 1'b1;
                    acc_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_done) begin
                    m_valid_next = 1'b1;
                    m_data_next  = fin_tag;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            fin_pend_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            r_low_reg    <= '0;
            r_high_reg   <= '0;
            s_low_reg    <= '0;
            s_high_reg   <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            fin_pend_reg <= fin_pend_next;
            m_valid_reg  <= m_valid_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            if (cfg_we) begin
                unique case (cfg_idx_e'(cfg_idx))
                    CFG_R_LOW:  r_low_reg  <= cfg_wdata;
                    CFG_R_HIGH: r_high_reg <= cfg_wdata;
                    CFG_S_LOW:  s_low_reg  <= cfg_wdata;
                    CFG_S_HIGH: s_high_reg <= cfg_wdata;
                endcase
            end
        end
        h_reg      <= h_next;
        d_reg      <= d_next;
        c_reg      <= c_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// File: rtl/poly1305_mac_chk.sv
`default_nettype none

module poly1305_mac_chk
    import poly_pkg::*;
(
    input wire logic             aclk,
    input wire logic             aresetn,
    input wire logic             s_valid,
    input wire logic             s_ready,
    input wire poly_in_t         s_data,
    input wire logic             m_valid,
    input wire logic             m_ready,
    input wire poly_out_t        m_data,
    input wire logic             cfg_we,
    input wire logic [1:0]       cfg_idx,
    input wire logic [CFG_W-1:0] cfg_wdata
);

    // a stalled tag holds until taken
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("tag dropped or changed while stalled");

    a_rst_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("tag valid right after reset");

    // after an accepted beat the block is busy in the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("beat accepted while previous one still in work");

    // a tag only appears at the end of a busy period
    a_tag_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("tag appeared without work in progress");

endmodule

bind poly1305_mac poly1305_mac_chk u_chk (.*);

`default_nettype wire
